FILE: rtl/clc_pkg.sv
// shared types and constants for the code lock controller
// no dependencies; every other rtl file imports this package
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

    // number of digits in the unlock code
    localparam int CODE_DIGITS = 6;
    localparam int DIGIT_W     = 4;
    localparam int CODE_W      = CODE_DIGITS * DIGIT_W;
    localparam int CARD_W      = 32;
    localparam int FAIL_W      = 4;
    localparam int KEY_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

    localparam logic [CNT_W-1:0] DIGITS_FULL = CNT_W'(CODE_DIGITS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (CODE_W > CARD_W) ? CODE_W : CARD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_STORED_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_CARD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd2;

    localparam logic [FAIL_W-1:0] MAX_FAIL_RESET = 4'd3;
    localparam logic [FAIL_W-1:0] FAIL_SATURATE  = 4'd15;

    // event codes
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_CARD = 1'b1;

    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CONFIRM   = 4'd10;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 4'd11;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_UNLOCK  = 3'd1,
        ST_WRONG   = 3'd2,
        ST_LOCKOUT = 3'd3,
        ST_REJECT  = 3'd4
    } status_t;

    typedef struct packed {
        logic [CODE_W-1:0] stored_code;
        logic [CARD_W-1:0] stored_card;
        logic [FAIL_W-1:0] max_failures;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [KEY_W-1:0]  key_code;
        logic [CARD_W-1:0] card_serial;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  digit_count;
        logic [FAIL_W-1:0] failure_count;
        logic              locked_out;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/clc_if.sv
// valid/ready channel interfaces for keypad/card events and lock results
// depends on clc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface clc_item_if import clc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [KEY_W-1:0]  key_code;
    logic [CARD_W-1:0] card_serial;

    modport source (output valid, output mode, output key_code, output card_serial,
                    input ready);
    modport sink   (input valid, input mode, input key_code, input card_serial,
                    output ready);
endinterface

interface clc_result_if import clc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    digit_count;
    logic [FAIL_W-1:0]   failure_count;
    logic                locked_out;

    modport source (output valid, output status, output digit_count,
                    output failure_count, output locked_out, input ready);
    modport sink   (input valid, input status, input digit_count,
                    input failure_count, input locked_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/clc_cfg_regs.sv
// configuration register file: stored code, stored card, failure limit
// depends on clc_pkg
`timescale 1ns / 1ps
`default_nettype none

module clc_cfg_regs import clc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STORED_CODE:  cfg_next.stored_code  = cfg_data[CODE_W-1:0];
                CFG_STORED_CARD:  cfg_next.stored_card  = cfg_data[CARD_W-1:0];
                CFG_MAX_FAILURES: cfg_next.max_failures = cfg_data[FAIL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stored_code  <= '0;
            cfg_reg.stored_card  <= '0;
            cfg_reg.max_failures <= MAX_FAIL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/clc_core.sv
// lock state: entry buffer, failure counter, lockout flag and their update
// depends on clc_pkg
`timescale 1ns / 1ps
`default_nettype none

module clc_core import clc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   res
);

    logic [DIGIT_W-1:0] digits_reg [CODE_DIGITS];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [FAIL_W-1:0]  failures_reg;
    logic [FAIL_W-1:0]  failures_next;
    logic               lockout_reg;
    logic               lockout_next;

    logic [CODE_W-1:0]  entry_word;
    logic               code_match;
    logic               card_match;
    logic [FAIL_W-1:0]  fail_inc;
    logic               digit_wr;
    status_t            status;

    // first buffered digit lands in the top nibble
    always_comb
    begin
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            entry_word[(CODE_DIGITS - 1 - i) * DIGIT_W +: DIGIT_W] = digits_reg[i];
        end
    end

    assign code_match = (count_reg == DIGITS_FULL) && (entry_word == cfg.stored_code);
    assign card_match = (item.card_serial == cfg.stored_card);
    assign fail_inc   = (failures_reg == FAIL_SATURATE) ? failures_reg
                                                        : failures_reg + 1'b1;

    always_comb
    begin
        count_next    = count_reg;
        failures_next = failures_reg;
        lockout_next  = lockout_reg;
        digit_wr      = 1'b0;
        status        = ST_IDLE;

        if (item.mode == MODE_CARD)
        begin
            if (lockout_reg || card_match)
            begin
                count_next    = '0;
                failures_next = '0;
                lockout_next  = 1'b0;
            end
            status = card_match ? ST_UNLOCK : ST_REJECT;
        end
        else if (!lockout_reg)
        begin
            unique case (item.key_code) inside
                [4'd0:KEY_DIGIT_MAX]:
                begin
                    if (count_reg < DIGITS_FULL)
                    begin
                        digit_wr   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                KEY_DELETE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                KEY_CONFIRM:
                begin
                    count_next = '0;
                    if (code_match)
                    begin
                        failures_next = '0;
                        status        = ST_UNLOCK;
                    end
                    else
                    begin
                        failures_next = fail_inc;
                        if (fail_inc >= cfg.max_failures)
                        begin
                            lockout_next = 1'b1;
                            status       = ST_LOCKOUT;
                        end
                        else
                        begin
                            status = ST_WRONG;
                        end
                    end
                end
                default:
                begin
                    status = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            failures_reg <= '0;
            lockout_reg  <= 1'b0;
        end
        else if (fire)
        begin
            count_reg    <= count_next;
            failures_reg <= failures_next;
            lockout_reg  <= lockout_next;
        end
    end

    // entry buffer holds payload only, count_reg says what is valid
    always_ff @(posedge clk)
    begin
        if (fire && digit_wr)
        begin
            digits_reg[count_reg[IDX_W-1:0]] <= item.key_code;
        end
    end

    assign res.status        = status;
    assign res.digit_count   = count_next;
    assign res.failure_count = failures_next;
    assign res.locked_out    = lockout_next;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DIGITS_FULL)
        else $error("entry count beyond code length");

    a_lockout_has_failures: assert property (@(posedge clk) disable iff (!rst_n)
        lockout_reg |-> (failures_reg != '0))
        else $error("lockout without any recorded failure");

    a_keys_ignored_in_lockout: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && lockout_reg && item.mode == MODE_KEY)
        |=> (lockout_reg && $stable(count_reg) && $stable(failures_reg)))
        else $error("key changed state during lockout");

    a_card_ends_lockout: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && lockout_reg && item.mode == MODE_CARD)
        |=> (!lockout_reg && count_reg == '0 && failures_reg == '0))
        else $error("card did not clear lockout");
`endif

endmodule

`default_nettype wire

FILE: rtl/code_lock_controller_top.sv
// top level of the keypad and card code lock controller
// depends on clc_pkg, clc_if, clc_cfg_regs and clc_core
`timescale 1ns / 1ps
`default_nettype none

// Code lock controller. Each transaction on the item channel is either a
// keypad key (mode 0: digits 0-9, confirm 10, delete 11, other codes
// ignored) or a card presentation (mode 1), and produces exactly one
// transaction on the result channel carrying the status and the lock state
// after the event. The block accepts one transaction per clock cycle while
// the result channel is not stalled; the input register takes the item when
// it is accepted and the result register takes its outcome when the item
// moves on, so each outcome passes through the input register and then the
// result register. The combinational compare and state update between those
// registers sets that rate. Both stages hold their contents under
// backpressure, so a full result register stalls the input stage and only
// then deasserts item.ready. Configuration (stored code, stored card,
// failure limit) is written through cfg_we/cfg_index/cfg_data and must only
// change while no transaction is in flight. No clearing pass is needed
// after reset: the block is ready as soon as rst_n rises.
module code_lock_controller_top import clc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    clc_item_if.sink                   item,
    clc_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // input stage
    logic    item_valid_reg;
    item_t   item_reg;

    // result stage
    logic    res_valid_reg;
    result_t res_reg;

    cfg_t    cfg;
    result_t res_next;
    logic    fire;

    // the item in the input stage moves on whenever the result stage is
    // empty or being drained in this cycle
    assign fire       = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || fire;

    clc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                item_valid_reg <= item.valid;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.mode        <= item.mode;
            item_reg.key_code    <= item.key_code;
            item_reg.card_serial <= item.card_serial;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.status        = res_reg.status;
    assign result.digit_count   = res_reg.digit_count;
    assign result.failure_count = res_reg.failure_count;
    assign result.locked_out    = res_reg.locked_out;

`ifndef SYNTH
    a_fire_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("processed transaction did not reach result stage");

    a_input_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !fire) |=> item_valid_reg)
        else $error("stalled input stage lost its transaction");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> item.ready)
        else $error("empty input stage not ready");
`endif

endmodule

`default_nettype wire
